/* rtl/core/utsh_pkg.sv */
// ----------------------------------------------------------------------------
// utsh_pkg
// Shared types and constants for the token stream hasher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package utsh_pkg;

  localparam int unsigned MAX_TOKEN_BYTES = 4096;
  localparam int unsigned LEN_W           = 13;
  localparam int unsigned LA_DEPTH        = 5;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;

  localparam logic [1:0] MODE_DOC  = 2'd0;
  localparam logic [1:0] MODE_SENT = 2'd1;

  localparam logic RES_TOKEN = 1'b0;
  localparam logic RES_TXN   = 1'b1;

  localparam logic [2:0] SEQ_UNDEC = 3'd0;
  localparam logic [2:0] SEQ_BAD   = 3'd7;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       buffer_last;
  } in_word_t;

  typedef struct packed {
    logic             result_kind;
    logic [63:0]      token_hash;
    logic [LEN_W-1:0] token_length;
    logic             run_end;
  } out_word_t;

  typedef struct packed {
    logic       wait_more;
    logic [2:0] st_n;
    logic [2:0] drop_n;
    logic       fin_tok;
    logic       fin_txn;
  } dec_t;

  typedef struct packed {
    logic accept;
    logic latch_dec;
    logic latch_flush;
    logic store;
    logic mix_load;
    logic mul_step;
    logic mix_next;
    logic emit_tok;
    logic emit_txn;
    logic clr_txn;
    logic drop;
    logic finish_pend;
  } cmd_t;

  typedef struct packed {
    logic dec_wait;
    logic final_byte;
    logic store_left;
    logic fin_tok;
    logic tok_nonempty;
    logic fin_txn;
    logic txn_open;
    logic mul_last;
    logic pend_valid;
    logic out_free;
    logic flush;
  } status_t;

endpackage

`default_nettype wire

/* rtl/core/utf8_token_stream_hasher_core.sv */
// ----------------------------------------------------------------------------
// utf8_token_stream_hasher_core
// Byte-stream word tokenizer with fmix64(FNV-1a-64 xor length) token hashes.
// ----------------------------------------------------------------------------
// One text byte per input word. A byte that only waits in the lookahead passes
// through accept, decide and done. Each decision on the head of the lookahead
// goes through latch, a store for each hashed byte, token check, transaction
// check and drop, and each finished token adds load, first product, reload,
// second product and emit (fmix64 runs its two 64-bit products on one 32x32
// multiplier). A full output stalls the sequencer.
// Results leave through an output register with a one-word holding slot,
// so the last result of a byte is flagged with run_end. A new byte is taken
// while that word still waits at the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_token_stream_hasher_core
  import utsh_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_word_t   in_word_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_word_t       out_word_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  utsh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  utsh_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

/* rtl/core/utsh_datapath.sv */
// ----------------------------------------------------------------------------
// utsh_datapath
// Lookahead buffer, byte classifier, FNV-1a accumulator, fmix64 multiplier
// and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utsh_datapath
  import utsh_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_word_t  in_word_i,
  input  wire logic      cfg_valid_i,
  input  wire logic [1:0] cfg_data_i,
  input  wire cmd_t      cmd_i,
  output status_t        status_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_word_o
);

  logic [1:0]             mode_q;
  logic [LA_DEPTH-1:0][7:0] la_q;
  logic [2:0]             cnt_q;
  logic [63:0]            acc_q;
  logic [LEN_W-1:0]       len_q;
  logic                   txn_q;
  logic                   final_q;
  dec_t                   dec_q;
  logic                   flush_q;
  logic [2:0]             st_idx_q;
  logic [63:0]            mul_a_q;
  logic [63:0]            mul_acc_q;
  logic [1:0]             mstep_q;
  logic                   csel_q;
  logic [LEN_W-1:0]       mix_len_q;
  logic                   pend_v_q;
  out_word_t              pend_q;
  logic                   out_v_q;
  out_word_t              out_q;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic [2:0] seq_check(input logic [LA_DEPTH-1:0][7:0] la,
                                           input logic pos, input logic [2:0] cnt,
                                           input logic fin);
    logic [7:0] c;
    logic [7:0] b;
    logic [2:0] need;
    logic [2:0] res;
    logic [2:0] p;
    logic       done;
    c    = la[3'(pos)];
    need = 3'd0;
    done = 1'b0;
    res  = SEQ_BAD;
    if (c < 8'h80) begin
      res  = 3'd1;
      done = 1'b1;
    end else if (c >= 8'hc2 && c <= 8'hdf) begin
      need = 3'd2;
    end else if (c >= 8'he0 && c <= 8'hef) begin
      need = 3'd3;
    end else if (c >= 8'hf0 && c <= 8'hf4) begin
      need = 3'd4;
    end else begin
      done = 1'b1;
    end
    if (!done) res = need;
    for (int k = 1; k < 4; k++) begin
      p = 3'({2'b00, pos} + 3'(k));
      if (!done && 3'(k) < need) begin
        if (p >= cnt) begin
          res  = fin ? SEQ_BAD : SEQ_UNDEC;
          done = 1'b1;
        end else begin
          b = la[p];
          if (b[7:6] != 2'b10) begin
            res  = SEQ_BAD;
            done = 1'b1;
          end else if (k == 1) begin
            if ((c == 8'he0 && b < 8'ha0) || (c == 8'hed && b > 8'h9f) ||
                (c == 8'hf0 && b < 8'h90) || (c == 8'hf4 && b > 8'h8f)) begin
              res  = SEQ_BAD;
              done = 1'b1;
            end
          end
        end
      end
    end
    return res;
  endfunction

  // head-of-buffer decision
  dec_t       dec;
  logic [7:0] c0;
  logic [7:0] c1;
  logic [2:0] r0;
  logic [2:0] r1;
  logic       right;
  logic       len_room;

  always_comb begin
    c0       = la_q[0];
    c1       = la_q[1];
    r0       = seq_check(la_q, 1'b0, cnt_q, final_q);
    r1       = seq_check(la_q, 1'b1, cnt_q, final_q);
    len_room = len_q < LEN_W'(MAX_TOKEN_BYTES);
    right    = 1'b0;
    dec      = '0;
    dec.drop_n = 3'd1;
    if (cnt_q == 3'd0) begin
      dec.wait_more = 1'b1;
    end else if (is_alnum(c0)) begin
      dec.st_n = len_room ? 3'd1 : 3'd0;
    end else if (c0 >= 8'h80) begin
      if (r0 == SEQ_UNDEC) begin
        dec.wait_more = 1'b1;
      end else if (r0 == SEQ_BAD) begin
        dec.fin_tok = 1'b1;
      end else begin
        dec.drop_n = r0;
        dec.st_n   = (({1'b0, len_q} + (LEN_W+1)'(r0)) <= (LEN_W+1)'(MAX_TOKEN_BYTES))
                     ? r0 : 3'd0;
      end
    end else if (c0 == 8'h2d || c0 == 8'h5f || c0 == 8'h27) begin
      if (cnt_q < 3'd2) begin
        if (!final_q) dec.wait_more = 1'b1;
      end else if (is_alnum(c1)) begin
        right = 1'b1;
      end else if (c1 >= 8'h80) begin
        if (r1 == SEQ_UNDEC) dec.wait_more = 1'b1;
        right = (r1 != SEQ_UNDEC) && (r1 != SEQ_BAD);
      end
      if (len_q != '0 && right) dec.st_n = len_room ? 3'd1 : 3'd0;
      else                      dec.fin_tok = 1'b1;
    end else begin
      dec.fin_tok = 1'b1;
      dec.fin_txn = (mode_q == MODE_DOC && c0 == 8'h0a) ||
                    (mode_q == MODE_SENT && (c0 == 8'h2e || c0 == 8'h3f || c0 == 8'h21));
    end
  end

  // FNV step
  logic [7:0]  sb;
  logic [63:0] fx;
  logic [63:0] fnv_d;
  always_comb begin
    sb    = la_q[st_idx_q];
    if (sb >= 8'h41 && sb <= 8'h5a) sb = sb + 8'd32;
    fx    = acc_q ^ {56'h0, sb};
    fnv_d = (fx << 40) + (fx * 64'h1b3);
  end

  // shared 32x32 multiplier, low 64 bits of a 64x64 product in three steps
  logic [63:0] mc;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] mp;
  logic [63:0] mix_x;
  logic [63:0] mix_out;
  always_comb begin
    mc      = csel_q ? MIX_C2 : MIX_C1;
    ma      = (mstep_q == 2'd2) ? mul_a_q[63:32] : mul_a_q[31:0];
    mb      = (mstep_q == 2'd1) ? mc[63:32] : mc[31:0];
    mp      = 64'(ma) * 64'(mb);
    mix_x   = acc_q ^ 64'(len_q);
    mix_out = mul_acc_q ^ (mul_acc_q >> 33);
  end

  logic      out_free;
  out_word_t tok_w;
  out_word_t txn_w;
  assign out_free = !out_v_q || out_ready_i;
  always_comb begin
    tok_w              = '0;
    tok_w.result_kind  = RES_TOKEN;
    tok_w.token_hash   = mix_out;
    tok_w.token_length = mix_len_q;
    txn_w              = '0;
    txn_w.result_kind  = RES_TXN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_DOC;
      cnt_q    <= '0;
      acc_q    <= FNV_BASIS;
      len_q    <= '0;
      txn_q    <= 1'b0;
      final_q  <= 1'b0;
      dec_q    <= '0;
      flush_q  <= 1'b0;
      st_idx_q <= '0;
      mstep_q  <= '0;
      csel_q   <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) mode_q <= cfg_data_i;
      if (cmd_i.accept) begin
        final_q <= in_word_i.buffer_last;
        if (cnt_q < 3'(LA_DEPTH)) cnt_q <= cnt_q + 3'd1;
      end
      if (cmd_i.latch_dec) begin
        dec_q    <= dec;
        flush_q  <= 1'b0;
        st_idx_q <= '0;
      end
      if (cmd_i.latch_flush) begin
        dec_q         <= '0;
        dec_q.fin_tok <= 1'b1;
        dec_q.fin_txn <= (mode_q == MODE_DOC) || (mode_q == MODE_SENT);
        flush_q       <= 1'b1;
        st_idx_q      <= '0;
      end
      if (cmd_i.store) begin
        acc_q    <= fnv_d;
        len_q    <= len_q + LEN_W'(1);
        st_idx_q <= st_idx_q + 3'd1;
      end
      if (cmd_i.mix_load) begin
        acc_q   <= FNV_BASIS;
        len_q   <= '0;
        mstep_q <= '0;
        csel_q  <= 1'b0;
        if (mode_q == MODE_DOC || mode_q == MODE_SENT) txn_q <= 1'b1;
      end
      if (cmd_i.mix_next) begin
        mstep_q <= '0;
        csel_q  <= 1'b1;
      end
      if (cmd_i.mul_step) mstep_q <= (mstep_q == 2'd2) ? 2'd0 : mstep_q + 2'd1;
      if (cmd_i.clr_txn) txn_q <= 1'b0;
      if (cmd_i.drop) begin
        cnt_q <= cnt_q - dec_q.drop_n;
        if (flush_q) begin
          txn_q <= 1'b0;
          acc_q <= FNV_BASIS;
          len_q <= '0;
        end
      end
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      if ((cmd_i.emit_tok || cmd_i.emit_txn) && pend_v_q) out_v_q <= 1'b1;
      if (cmd_i.emit_tok || cmd_i.emit_txn) pend_v_q <= 1'b1;
      if (cmd_i.finish_pend) begin
        out_v_q  <= 1'b1;
        pend_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && cnt_q < 3'(LA_DEPTH)) la_q[cnt_q] <= in_word_i.text_byte;
    if (cmd_i.drop) la_q <= la_q >> {dec_q.drop_n, 3'b000};
    if (cmd_i.mix_load) begin
      mul_a_q   <= mix_x ^ (mix_x >> 33);
      mix_len_q <= len_q;
    end
    if (cmd_i.mix_next) mul_a_q <= mix_out;
    if (cmd_i.mul_step) begin
      if (mstep_q == 2'd0) mul_acc_q <= mp;
      else                 mul_acc_q <= mul_acc_q + {mp[31:0], 32'h0};
    end
    if ((cmd_i.emit_tok || cmd_i.emit_txn) && pend_v_q) begin
      out_q         <= pend_q;
      out_q.run_end <= 1'b0;
    end
    if (cmd_i.emit_tok) pend_q <= tok_w;
    if (cmd_i.emit_txn) pend_q <= txn_w;
    if (cmd_i.finish_pend) begin
      out_q         <= pend_q;
      out_q.run_end <= 1'b1;
    end
  end

  always_comb begin
    status_o.dec_wait     = dec.wait_more;
    status_o.final_byte   = final_q;
    status_o.store_left   = st_idx_q < dec_q.st_n;
    status_o.fin_tok      = dec_q.fin_tok;
    status_o.tok_nonempty = len_q != '0;
    status_o.fin_txn      = dec_q.fin_txn;
    status_o.txn_open     = txn_q;
    status_o.mul_last     = mstep_q == 2'd2;
    status_o.pend_valid   = pend_v_q;
    status_o.out_free     = out_free;
    status_o.flush        = flush_q;
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

/* rtl/core/utsh_ctrl.sv */
// ----------------------------------------------------------------------------
// utsh_ctrl
// Sequencer: accept, decide, hash bytes, mix, emit, drop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utsh_ctrl
  import utsh_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_STORE, S_MIX, S_MUL1, S_NEXT, S_MUL2,
    S_TOK, S_TXN, S_DROP, S_DONE
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   can_emit;

  assign can_emit = !status_i.pend_valid || status_i.out_free;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!status_i.dec_wait) begin
          cmd_o.latch_dec = 1'b1;
          state_d         = S_STORE;
        end else if (status_i.final_byte) begin
          cmd_o.latch_flush = 1'b1;
          state_d           = S_STORE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_STORE: begin
        if (status_i.store_left) cmd_o.store = 1'b1;
        else if (status_i.fin_tok && status_i.tok_nonempty) state_d = S_MIX;
        else state_d = S_TXN;
      end
      S_MIX: begin
        cmd_o.mix_load = 1'b1;
        state_d        = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul_step = 1'b1;
        if (status_i.mul_last) state_d = S_NEXT;
      end
      S_NEXT: begin
        cmd_o.mix_next = 1'b1;
        state_d        = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul_step = 1'b1;
        if (status_i.mul_last) state_d = S_TOK;
      end
      S_TOK: begin
        if (can_emit) begin
          cmd_o.emit_tok = 1'b1;
          state_d        = S_TXN;
        end
      end
      S_TXN: begin
        if (!status_i.fin_txn) begin
          state_d = S_DROP;
        end else if (!status_i.txn_open) begin
          state_d = S_DROP;
        end else if (can_emit) begin
          cmd_o.emit_txn = 1'b1;
          cmd_o.clr_txn  = 1'b1;
          state_d        = S_DROP;
        end
      end
      S_DROP: begin
        cmd_o.drop = 1'b1;
        state_d    = status_i.flush ? S_DONE : S_DECIDE;
      end
      S_DONE: begin
        if (!status_i.pend_valid) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.finish_pend = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule

`default_nettype wire

/* rtl/core/utsh_checker.sv */
// ----------------------------------------------------------------------------
// utsh_checker
// Port-level checks on the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utsh_checker
  import utsh_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_word_t out_word_o
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_word_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_word_o))
    else $error("result word changed while stalled");

  a_txn_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.result_kind == RES_TXN |->
      out_word_o.token_hash == '0 && out_word_o.token_length == '0)
    else $error("transaction end carries hash or length");

  a_tok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.result_kind == RES_TOKEN |->
      out_word_o.token_length != '0 &&
      out_word_o.token_length <= LEN_W'(MAX_TOKEN_BYTES))
    else $error("token length out of range");

endmodule

bind utf8_token_stream_hasher_core utsh_checker u_utsh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire

/* tb/utf8_token_stream_hasher_core_chk.sv */
// ----------------------------------------------------------------------------
// utf8_token_stream_hasher_core_chk
// Watches the text, result and mode channels of the token hasher and checks
// every result word in order against a behavioral copy of the tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_token_stream_hasher_core_chk
  import utsh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_word_t    in_word_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_word_t   out_word_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_data_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          tok_cnt_o,
  output int          txn_cnt_o
);

  localparam logic [63:0] FNV_MUL = 64'h100000001b3;

  logic [1:0]       mode_q;
  logic [7:0]       la_q [LA_DEPTH];
  int unsigned      la_cnt;
  logic [63:0]      acc_q;
  int unsigned      tok_len;
  logic             txn_open;
  out_word_t        exp_q [$];
  out_word_t        step_q [$];

  function automatic logic [63:0] fmix64(logic [63:0] k);
    k ^= k >> 33;
    k = k * MIX_C1;
    k ^= k >> 33;
    k = k * MIX_C2;
    k ^= k >> 33;
    return k;
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
  endfunction

  // 0 undecided, -1 invalid, else sequence length
  function automatic int utf8_len(int unsigned pos, logic fin);
    logic [7:0] c, b;
    int need;
    c = la_q[pos];
    if (c < 8'h80) return 1;
    if (c >= 8'hC2 && c <= 8'hDF) need = 2;
    else if (c >= 8'hE0 && c <= 8'hEF) need = 3;
    else if (c >= 8'hF0 && c <= 8'hF4) need = 4;
    else return -1;
    for (int k = 1; k < need; k++) begin
      if (pos + k >= la_cnt) return fin ? -1 : 0;
      b = la_q[pos + k];
      if (b[7:6] != 2'b10) return -1;
      if (k == 1) begin
        if (c == 8'hE0 && b < 8'hA0) return -1;
        if (c == 8'hED && b > 8'h9F) return -1;
        if (c == 8'hF0 && b < 8'h90) return -1;
        if (c == 8'hF4 && b > 8'h8F) return -1;
      end
    end
    return need;
  endfunction

  task automatic push_res(logic kind, logic [63:0] h, int unsigned len);
    out_word_t w;
    w.result_kind  = kind;
    w.token_hash   = h;
    w.token_length = len[LEN_W-1:0];
    w.run_end      = 1'b0;
    if (step_q.size() < 4) step_q.push_back(w);
  endtask

  task automatic hash_byte(logic [7:0] b);
    acc_q = (acc_q ^ {56'd0, b}) * FNV_MUL;
    tok_len++;
  endtask

  task automatic close_token();
    if (tok_len == 0) return;
    push_res(RES_TOKEN, fmix64(acc_q ^ 64'(tok_len)), tok_len);
    if (mode_q <= MODE_SENT) txn_open = 1'b1;
    acc_q = FNV_BASIS;
    tok_len = 0;
  endtask

  task automatic close_txn();
    if (txn_open) push_res(RES_TXN, 64'd0, 0);
    txn_open = 1'b0;
  endtask

  task automatic pop_front(int unsigned n);
    if (n > la_cnt) n = la_cnt;
    for (int i = 0; i < LA_DEPTH; i++) la_q[i] = (i + n < LA_DEPTH) ? la_q[i + n] : 8'd0;
    la_cnt -= n;
  endtask

  task automatic tokenize_byte(in_word_t w);
    logic [7:0] c, nx;
    logic fin, right;
    int r;
    fin = w.buffer_last;
    step_q.delete();
    if (la_cnt < LA_DEPTH) begin
      la_q[la_cnt] = w.text_byte;
      la_cnt++;
    end
    while (la_cnt > 0) begin
      c = la_q[0];
      if (is_alnum(c)) begin
        if (tok_len < MAX_TOKEN_BYTES) hash_byte((c >= "A" && c <= "Z") ? c + 8'd32 : c);
        pop_front(1);
      end else if (c >= 8'h80) begin
        r = utf8_len(0, fin);
        if (r == 0) break;
        if (r > 0) begin
          if (tok_len + r <= MAX_TOKEN_BYTES)
            for (int k = 0; k < r; k++) hash_byte(la_q[k]);
          pop_front(r);
        end else begin
          close_token();
          pop_front(1);
        end
      end else if (c == "-" || c == "_" || c == "'") begin
        right = 1'b0;
        if (la_cnt < 2) begin
          if (!fin) break;
        end else begin
          nx = la_q[1];
          if (is_alnum(nx)) begin
            right = 1'b1;
          end else if (nx >= 8'h80) begin
            r = utf8_len(1, fin);
            if (r == 0) break;
            right = r > 0;
          end
        end
        if (tok_len > 0 && right) begin
          if (tok_len < MAX_TOKEN_BYTES) hash_byte(c);
        end else begin
          close_token();
        end
        pop_front(1);
      end else begin
        close_token();
        if ((mode_q == MODE_DOC && c == 8'h0A) ||
            (mode_q == MODE_SENT && (c == "." || c == "?" || c == "!")))
          close_txn();
        pop_front(1);
      end
    end
    if (fin) begin
      close_token();
      if (mode_q <= MODE_SENT) close_txn();
      txn_open = 1'b0;
      acc_q = FNV_BASIS;
      tok_len = 0;
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].run_end = 1'b1;
    foreach (step_q[i]) exp_q.push_back(step_q[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t e;
    if (!rst_ni) begin
      mode_q = MODE_DOC;
      la_cnt = 0;
      acc_q = FNV_BASIS;
      tok_len = 0;
      txn_open = 1'b0;
      foreach (la_q[i]) la_q[i] = 8'd0;
      exp_q.delete();
      fail_cnt_o <= 0;
      tok_cnt_o <= 0;
      txn_cnt_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) mode_q = cfg_data_i;
      if (in_valid_i && in_ready_i) tokenize_byte(in_word_i);
      if (out_valid_i && out_ready_i) begin
        if (out_word_i.result_kind == RES_TXN) txn_cnt_o <= txn_cnt_o + 1;
        else tok_cnt_o <= tok_cnt_o + 1;
        if (exp_q.size() == 0) begin
          if (fail_cnt_o < 10) $display("unexpected result word %h", out_word_i);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          e = exp_q.pop_front();
          if (e !== out_word_i) begin
            if (fail_cnt_o < 10)
              $display("mismatch: exp kind %0d hash %h len %0d end %0d / got %0d %h %0d %0d",
                       e.result_kind, e.token_hash, e.token_length, e.run_end,
                       out_word_i.result_kind, out_word_i.token_hash,
                       out_word_i.token_length, out_word_i.run_end);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
    end
    pending_o <= exp_q.size();
  end

endmodule

/* tb/utf8_token_stream_hasher_core_tb.sv */
// ----------------------------------------------------------------------------
// utf8_token_stream_hasher_core_tb
// Drives text words with random gaps, output stalls and mode changes into the
// token hasher; a side checker predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_token_stream_hasher_core_tb;
  import utsh_pkg::*;

  localparam int LIMIT = 400000;
  localparam int DRAIN = 200;

  logic        clk, rst_n;
  logic        in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  in_word_t    in_word;
  out_word_t   out_word;
  logic [1:0]  cfg_data;
  int          fails, pending, n_tok, n_txn, cycles;
  logic        hold_req;
  int          sent;

  utf8_token_stream_hasher_core i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_word_o(out_word),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  utf8_token_stream_hasher_core_chk i_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_word_i(in_word),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_word_i(out_word),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .fail_cnt_o(fails), .pending_o(pending), .tok_cnt_o(n_tok), .txn_cnt_o(n_txn)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(5, 30);
  endfunction

  // receiver: random stalls, or a long hold on request
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= 1'b1;
      n = $urandom_range(1, 40);
      repeat (n) @(posedge clk);
      if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        n = gap_len() + 1;
        repeat (n) @(posedge clk);
      end
    end
  end

  // valid stays up across back-to-back words; quiesce drops it
  task automatic send_byte(logic [7:0] b, logic fin);
    int g;
    if (sent % 30 > 20) g = 0; else g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{text_byte: b, buffer_last: fin};
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_str(string s, logic fin_at_end);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin_at_end && i == s.len() - 1);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_mode(logic [1:0] m);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0, 1, 2: return 8'($urandom_range("a", "z"));
      3:       return 8'($urandom_range("A", "Z"));
      4:       return 8'($urandom_range("0", "9"));
      5:       begin
        case ($urandom_range(0, 2))
          0: return "-";
          1: return "_";
          default: return "'";
        endcase
      end
      6:       begin
        case ($urandom_range(0, 4))
          0: return 8'h0A;
          1: return ".";
          2: return "?";
          3: return "!";
          default: return " ";
        endcase
      end
      7, 8:    return 8'($urandom_range(8'h80, 8'hBF));
      9:       return 8'($urandom_range(8'hC0, 8'hFF));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // valid UTF-8 leads, with some second bytes out of range after E0, ED, F0 and F4
  task automatic send_utf8();
    logic [7:0] lead, b1;
    int n;
    case ($urandom_range(0, 5))
      0: begin lead = 8'($urandom_range(8'hC2, 8'hDF)); n = 2; b1 = 8'($urandom_range(8'h80, 8'hBF)); end
      1: begin lead = 8'hE0; n = 3; b1 = 8'($urandom_range(8'h80, 8'hBF)); end
      2: begin lead = 8'hED; n = 3; b1 = 8'($urandom_range(8'h80, 8'hBF)); end
      3: begin lead = 8'($urandom_range(8'hE1, 8'hEF)); n = 3; b1 = 8'($urandom_range(8'h80, 8'hBF)); end
      4: begin lead = 8'hF0; n = 4; b1 = 8'($urandom_range(8'h80, 8'hBF)); end
      default: begin lead = 8'($urandom_range(8'hF1, 8'hF4)); n = 4; b1 = 8'($urandom_range(8'h80, 8'hBF)); end
    endcase
    send_byte(lead, 1'b0);
    send_byte(b1, 1'b0);
    for (int k = 2; k < n; k++) send_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
  endtask

  initial begin
    int mix, len_t;
    in_valid = 1'b0; in_word = '0; cfg_valid = 1'b0; cfg_data = MODE_DOC;
    hold_req = 1'b0; sent = 0; cycles = 0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_mode(MODE_DOC);
    send_str("Az09 a-b _x c'd\n", 1'b0);
    send_byte(8'hC3, 1'b0); send_byte(8'hA9, 1'b0);
    send_byte(8'hE0, 1'b0); send_byte(8'h9F, 1'b0);
    send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0);
    send_byte(8'hF4, 1'b0); send_byte(8'h90, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b0);
    send_byte("x", 1'b0); send_byte("-", 1'b1);
    set_mode(MODE_SENT);
    send_str("ab. c? d!-", 1'b1);

    // receiver holds off while bytes keep coming
    hold_req = 1'b1;
    send_str("fill up the output and stall the input port now x", 1'b0);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_mode(MODE_DOC);
        1: set_mode(2'd2);
        2: set_mode(2'd3);
        3: set_mode(MODE_SENT);
        default: set_mode(MODE_DOC);
      endcase
      for (int i = 0; i < 8; i++) begin
        mix = $urandom_range(0, 9);
        if (mix < 4) begin
          len_t = $urandom_range(1, 6);
          for (int j = 0; j < len_t; j++) send_byte(8'($urandom_range("a", "z")), 1'b0);
          send_byte(pick_byte(), $urandom_range(0, 15) == 0);
        end else if (mix < 6) begin
          send_utf8();
        end else begin
          send_byte(pick_byte(), $urandom_range(0, 20) == 0);
        end
      end
      send_byte(" ", 1'b1);
    end

    quiesce();
    $display("covered %0d text words across all boundary modes, %0d tokens, %0d txn ends",
             sent, n_tok, n_txn);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fails);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/utsh_pkg.sv
rtl/core/utsh_datapath.sv
rtl/core/utsh_ctrl.sv
rtl/core/utf8_token_stream_hasher_core.sv
rtl/core/utsh_checker.sv
tb/utf8_token_stream_hasher_core_chk.sv
tb/utf8_token_stream_hasher_core_tb.sv
